// ----- design/sca_pkg.sv -----
// shared types and constants for the servo center auto trim block
package sca_pkg;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 24;
  localparam int CENTER_W    = 16;
  localparam int SUM_W       = 40;
  localparam int COUNT_W     = 24;
  localparam int TIME_W      = 32;
  localparam int WINDOW_W    = 16;
  localparam int IDX_W       = 3;
  localparam int MASK_W      = 8;
  localparam int SCOUNT_W    = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd2000;
  localparam logic [SCOUNT_W-1:0] SCOUNT_RESET = 4'd8;

  localparam logic [CFG_IDX_W-1:0] REG_SERVO_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_MASK   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW      = 2'd2;

  localparam logic KIND_AVERAGE = 1'b0;
  localparam logic KIND_RESTORE = 1'b1;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_COLLECT = 2'd1,
    MODE_PENDING = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_SCAN_READ,
    ST_SCAN_CHECK,
    ST_DIVIDE,
    ST_PUSH,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [CENTER_W-1:0] center;
    logic [SUM_W-1:0]    sum;
    logic [COUNT_W-1:0]  count;
  } entry_t;

  typedef struct packed {
    logic cap_item;
    logic rd_scan;
    logic mem_we;
    logic wr_capture;
    logic start_load;
    logic scan_clr;
    logic scan_inc;
    logic div_start;
    logic hold_clr;
    logic hold_load;
    logic scan_kind;
    logic out_push;
    logic out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic idx_skip;
    logic last;
    logic sw;
    logic armed;
    logic item_trim;
    logic count_free;
    logic window_hit;
    logic scan_end;
    logic scan_trim;
    logic count_nz;
    logic div_done;
    logic hold_valid;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- design/sca_ram.sv -----
// generic single write port ram with registered read
module sca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/sca_div.sv -----
// iterative restoring divider, one quotient bit per cycle
module sca_div
  import sca_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [SUM_W-1:0]   dividend,
  input  logic [COUNT_W-1:0] divisor,
  output logic               done,
  output logic [SUM_W-1:0]   quotient
);

  localparam int CW = $clog2(SUM_W + 1);

  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               done_r, done_nxt;
  logic [SUM_W-1:0]   q_r, q_nxt;
  logic [COUNT_W-1:0] rem_r, rem_nxt;
  logic [COUNT_W-1:0] dsr_r, dsr_nxt;
  logic [COUNT_W:0]   trial;
  logic [COUNT_W:0]   diff;

  always_comb begin
    trial    = {rem_r, q_r[SUM_W-1]};
    diff     = trial - {1'b0, dsr_r};
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      cnt_nxt = CW'(SUM_W);
      q_nxt   = dividend;
      rem_nxt = '0;
      dsr_nxt = divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - CW'(1);
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = diff[COUNT_W-1:0];
        q_nxt   = {q_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[COUNT_W-1:0];
        q_nxt   = {q_r[SUM_W-2:0], 1'b0};
      end
      done_nxt = (cnt_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> cnt_r == '0)
    else $error("divider started while busy");

endmodule

// ----- design/sca_datapath.sv -----
// datapath: config registers, item capture, servo table, divider, result registers
module sca_datapath
  import sca_pkg::*;
#(
  parameter int SERVOS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dp_cmd_t                cmd,
  output dp_stat_t               stat,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_switch_on,
  input  logic                   in_armed,
  input  logic [TIME_W-1:0]      in_now_ms,
  input  logic [IDX_W-1:0]       in_servo_index,
  input  logic [CENTER_W-1:0]    in_servo_output,
  input  logic [CENTER_W-1:0]    in_current_center,
  input  logic                   out_tready,
  output logic                   out_tvalid,
  output logic [IDX_W-1:0]       out_target_servo,
  output logic [CENTER_W-1:0]    out_new_center,
  output logic                   out_write_kind,
  output logic                   out_last_write
);

  localparam int NW = $clog2(SERVOS + 1);
  localparam int AW = SERVOS > 1 ? $clog2(SERVOS) : 1;

  logic [SCOUNT_W-1:0] servo_count_r;
  logic [MASK_W-1:0]   mask_r;
  logic [WINDOW_W-1:0] window_r;

  logic                item_sw_r, item_armed_r;
  logic [TIME_W-1:0]   item_now_r;
  logic [IDX_W-1:0]    item_idx_r;
  logic [CENTER_W-1:0] item_out_r, item_ctr_r;
  logic [TIME_W-1:0]   start_r;
  logic [NW-1:0]       scan_r;

  logic                hold_valid_r, hold_valid_nxt;
  logic [IDX_W-1:0]    hold_servo_r;
  logic [CENTER_W-1:0] hold_center_r;
  logic                hold_kind_r;

  logic                out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]    out_servo_r;
  logic [CENTER_W-1:0] out_center_r;
  logic                out_kind_r, out_last_r;

  logic [NW-1:0]       n_eff;
  logic [4:0]          n5, idx5, scan5;
  logic [TIME_W-1:0]   tdiff;
  logic [AW-1:0]       raddr;
  entry_t              rd_entry, wr_entry;
  logic                div_done;
  logic [SUM_W-1:0]    quotient;
  logic [CENTER_W-1:0] new_value;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      servo_count_r <= SCOUNT_RESET;
      mask_r        <= '0;
      window_r      <= WINDOW_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SERVO_COUNT: servo_count_r <= cfg_data[SCOUNT_W-1:0];
        REG_TRIM_MASK:   mask_r        <= cfg_data[MASK_W-1:0];
        REG_WINDOW:      window_r      <= cfg_data[WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  // effective servo count, clamped to 1..SERVOS
  always_comb begin
    if (servo_count_r == '0) begin
      n_eff = NW'(1);
    end else if ({1'b0, servo_count_r} > 5'(SERVOS)) begin
      n_eff = NW'(SERVOS);
    end else begin
      n_eff = NW'(servo_count_r);
    end
  end

  assign n5    = 5'(n_eff);
  assign idx5  = {2'b00, item_idx_r};
  assign scan5 = 5'(scan_r);
  assign tdiff = item_now_r - start_r;

  always_ff @(posedge clk) begin
    if (cmd.cap_item) begin
      item_sw_r    <= in_switch_on;
      item_armed_r <= in_armed;
      item_now_r   <= in_now_ms;
      item_idx_r   <= in_servo_index;
      item_out_r   <= in_servo_output;
      item_ctr_r   <= in_current_center;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
    end else if (cmd.start_load) begin
      start_r <= item_now_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      scan_r <= '0;
    end else if (cmd.scan_inc) begin
      scan_r <= scan_r + NW'(1);
    end
  end

  assign raddr = cmd.rd_scan ? AW'(scan_r) : AW'(item_idx_r);

  always_comb begin
    if (cmd.wr_capture) begin
      wr_entry.center = item_ctr_r;
      wr_entry.sum    = '0;
      wr_entry.count  = '0;
    end else begin
      wr_entry.center = rd_entry.center;
      wr_entry.sum    = rd_entry.sum + SUM_W'(item_out_r);
      wr_entry.count  = rd_entry.count + COUNT_W'(1);
    end
  end

  sca_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(SERVOS)
  ) u_table (
    .clk   (clk),
    .we    (cmd.mem_we),
    .waddr (AW'(item_idx_r)),
    .wdata (wr_entry),
    .raddr (raddr),
    .rdata (rd_entry)
  );

  sca_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (rd_entry.sum),
    .divisor  (rd_entry.count),
    .done     (div_done),
    .quotient (quotient)
  );

  assign new_value = (cmd.scan_kind == KIND_RESTORE) ? rd_entry.center
                                                     : quotient[CENTER_W-1:0];

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (cmd.hold_clr) begin
      hold_valid_nxt = 1'b0;
    end else if (cmd.hold_load) begin
      hold_valid_nxt = 1'b1;
    end else if (cmd.out_push && cmd.out_last) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_push) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    if (cmd.hold_load) begin
      hold_servo_r  <= scan5[IDX_W-1:0];
      hold_center_r <= new_value;
      hold_kind_r   <= cmd.scan_kind;
    end
    if (cmd.out_push) begin
      out_servo_r  <= hold_servo_r;
      out_center_r <= hold_center_r;
      out_kind_r   <= hold_kind_r;
      out_last_r   <= cmd.out_last;
    end
  end

  assign out_tvalid       = out_valid_r;
  assign out_target_servo = out_servo_r;
  assign out_new_center   = out_center_r;
  assign out_write_kind   = out_kind_r;
  assign out_last_write   = out_last_r;

  always_comb begin
    stat.idx_skip   = idx5 >= n5;
    stat.last       = idx5 == (n5 - 5'd1);
    stat.sw         = item_sw_r;
    stat.armed      = item_armed_r;
    stat.item_trim  = mask_r[item_idx_r];
    stat.count_free = rd_entry.count != COUNT_MAX;
    stat.window_hit = !tdiff[TIME_W-1] && (tdiff > TIME_W'(window_r));
    stat.scan_end   = scan_r == n_eff;
    stat.scan_trim  = (scan5 < 5'd8) && mask_r[scan5[IDX_W-1:0]];
    stat.count_nz   = rd_entry.count != '0;
    stat.div_done   = div_done;
    stat.hold_valid = hold_valid_r;
    stat.out_free   = !out_valid_r || out_tready;
  end

  a_last_clears_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_push && cmd.out_last) |=> !hold_valid_r)
    else $error("hold register still valid after final write");

endmodule

// ----- design/sca_ctrl.sv -----
// controller: trim mode and sequencing of item updates and result scans
module sca_ctrl
  import sca_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;
  mode_t  mode_r, mode_nxt;
  logic   kind_r, kind_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mode_r  <= MODE_IDLE;
      kind_r  <= KIND_AVERAGE;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      kind_r  <= kind_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    kind_nxt      = kind_r;
    cmd           = '0;
    cmd.scan_kind = kind_r;
    in_tready     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready    = 1'b1;
        cmd.cap_item = in_tvalid;
        if (in_tvalid) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_nxt = ST_IDLE;
        if (!stat.idx_skip) begin
          unique case (mode_r)
            MODE_COLLECT: begin
              if (!stat.sw || !stat.armed) begin
                if (stat.last) begin
                  mode_nxt = MODE_IDLE;
                end
              end else begin
                cmd.mem_we = stat.item_trim && stat.count_free;
                if (stat.last && stat.window_hit) begin
                  mode_nxt     = MODE_PENDING;
                  kind_nxt     = KIND_AVERAGE;
                  cmd.scan_clr = 1'b1;
                  cmd.hold_clr = 1'b1;
                  state_nxt    = ST_SCAN_READ;
                end
              end
            end
            MODE_PENDING: begin
              if (stat.last) begin
                if (!stat.sw) begin
                  mode_nxt     = MODE_IDLE;
                  kind_nxt     = KIND_RESTORE;
                  cmd.scan_clr = 1'b1;
                  cmd.hold_clr = 1'b1;
                  state_nxt    = ST_SCAN_READ;
                end else if (!stat.armed) begin
                  mode_nxt = MODE_IDLE;
                end
              end
            end
            default: begin
              if (stat.sw && stat.armed) begin
                cmd.mem_we     = stat.item_trim;
                cmd.wr_capture = 1'b1;
                if (stat.last) begin
                  cmd.start_load = 1'b1;
                  mode_nxt       = MODE_COLLECT;
                end
              end
            end
          endcase
        end
      end
      ST_SCAN_READ: begin
        cmd.rd_scan = 1'b1;
        state_nxt   = stat.scan_end ? ST_FLUSH : ST_SCAN_CHECK;
      end
      ST_SCAN_CHECK: begin
        cmd.rd_scan = 1'b1;
        if (kind_r == KIND_RESTORE) begin
          if (stat.scan_trim) begin
            state_nxt = ST_PUSH;
          end else begin
            cmd.scan_inc = 1'b1;
            state_nxt    = ST_SCAN_READ;
          end
        end else if (stat.scan_trim && stat.count_nz) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIVIDE;
        end else begin
          cmd.scan_inc = 1'b1;
          state_nxt    = ST_SCAN_READ;
        end
      end
      ST_DIVIDE: begin
        cmd.rd_scan = 1'b1;
        if (stat.div_done) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        cmd.rd_scan = 1'b1;
        if (!stat.hold_valid || stat.out_free) begin
          cmd.out_push  = stat.hold_valid;
          cmd.hold_load = 1'b1;
          cmd.scan_inc  = 1'b1;
          state_nxt     = ST_SCAN_READ;
        end
      end
      ST_FLUSH: begin
        if (!stat.hold_valid) begin
          state_nxt = ST_IDLE;
        end else if (stat.out_free) begin
          cmd.out_push = 1'b1;
          cmd.out_last = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_push_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_push |-> stat.out_free)
    else $error("result pushed into occupied output register");

  a_div_then_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> state_r == ST_DIVIDE && kind_r == KIND_AVERAGE)
    else $error("divider started outside an average scan");

  a_flush_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH && !stat.hold_valid) |=> state_r == ST_IDLE)
    else $error("flush with nothing held did not return to idle");

endmodule

// ----- design/servo_center_auto_trim.sv -----
// servo center auto trim top level
//
// Input stream: one transfer per servo per control tick, servos in ascending
// index order; the servo whose index is servo_count-1 closes the tick.
// Output stream: center writes, servo index and value in tdata, tuser set for
// a restored backup center, tlast on the final write of a run.
// Config channel: cfg_index selects servo count, trimmable mask or window;
// always ready. It must be written only while the block is idle; the block
// itself does not enforce this. An input transfer passes through accept,
// table read and table update. At a window end each trimmable servo with
// samples goes through the 40-step serial divider; a backup restore reads
// back stored centers. No input is taken while a run of writes is produced.
// One output register plus one held result decouple the scan from the
// receiver; when it stalls, the scan waits with the next result held.
// Reset puts the block in idle, clears start time, loads servo count 8,
// mask 0 and window 2000; the servo table has no reset.
module servo_center_auto_trim
  import sca_pkg::*;
#(
  parameter int SERVOS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // switch_on, armed, now_ms[31:0], servo_index[2:0], servo_output[15:0],
  // current_center[15:0], zero fill
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // target_servo[2:0], new_center[15:0], zero fill
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // write_kind
  output logic [0:0]             out_tuser,
  output logic                   out_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  dp_cmd_t             cmd;
  dp_stat_t            stat;
  logic [IDX_W-1:0]    target_servo;
  logic [CENTER_W-1:0] new_center;
  logic                write_kind;

  sca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sca_datapath #(
    .SERVOS(SERVOS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_switch_on      (in_tdata[0]),
    .in_armed          (in_tdata[1]),
    .in_now_ms         (in_tdata[33:2]),
    .in_servo_index    (in_tdata[36:34]),
    .in_servo_output   (in_tdata[52:37]),
    .in_current_center (in_tdata[68:53]),
    .out_tready        (out_tready),
    .out_tvalid        (out_tvalid),
    .out_target_servo  (target_servo),
    .out_new_center    (new_center),
    .out_write_kind    (write_kind),
    .out_last_write    (out_tlast)
  );

  assign out_tdata = {5'b00000, new_center, target_servo};
  assign out_tuser = write_kind;

endmodule
